// File: rtl/core/sha1s_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1s_pkg
// Shared types and constants for the byte-stream SHA-1 hasher.
// ---------------------------------------------------------------------------
package sha1s_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam int ROUNDS       = 80;
  localparam int DIGEST_WORDS = 5;

  localparam word_t H0_INIT = 32'h67452301;
  localparam word_t H1_INIT = 32'hEFCDAB89;
  localparam word_t H2_INIT = 32'h98BADCFE;
  localparam word_t H3_INIT = 32'h10325476;
  localparam word_t H4_INIT = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [6:0] LAST_RND  = 7'(ROUNDS - 1);
  localparam logic [2:0] LAST_WORD = 3'(DIGEST_WORDS - 1);

  // controls from the sequencer to the datapath
  typedef struct packed {
    logic       push_byte;
    logic [7:0] push_val;
    logic       init_work;
    logic       do_round;
    logic [6:0] rnd;
    logic       add_chain;
    logic       reinit_chain;
  } ctl_t;

endpackage

// File: rtl/core/sha1s_msg_sched.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1s_msg_sched
// Block buffer and message schedule in one 16-word shift line. Bytes shift
// in at the tail; during rounds the line shifts by a word per cycle and the
// expanded word enters at the tail.
// ---------------------------------------------------------------------------
module sha1s_msg_sched (
  input  logic             clk,
  input  sha1s_pkg::ctl_t  ctl,
  output sha1s_pkg::word_t w
);
  import sha1s_pkg::*;

  word_t sreg [16];
  word_t mix;
  word_t w_new;

  assign mix   = sreg[13] ^ sreg[8] ^ sreg[2] ^ sreg[0];
  assign w_new = {mix[30:0], mix[31]};
  assign w     = sreg[0];

  always_ff @(posedge clk) begin
    if (ctl.push_byte) begin
      // whole line moves up one byte so word 0 ends up big-endian
      for (int i = 0; i < 15; i++) begin
        sreg[i] <= {sreg[i][23:0], sreg[i+1][31:24]};
      end
      sreg[15] <= {sreg[15][23:0], ctl.push_val};
    end else if (ctl.do_round) begin
      for (int i = 0; i < 15; i++) begin
        sreg[i] <= sreg[i+1];
      end
      sreg[15] <= w_new;
    end
  end

endmodule

// File: rtl/core/sha1s_round_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1s_round_unit
// Working variables, one shared compression round and the chaining value.
// ---------------------------------------------------------------------------
module sha1s_round_unit (
  input  logic             clk,
  input  logic             rst,
  input  sha1s_pkg::ctl_t  ctl,
  input  sha1s_pkg::word_t w,
  input  logic [2:0]       word_sel,
  output sha1s_pkg::word_t digest
);
  import sha1s_pkg::*;

  word_t a, b, c, d, e;
  word_t h [DIGEST_WORDS];
  word_t f;
  word_t k;
  word_t t;

  always_comb begin
    if (ctl.rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctl.rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctl.rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t      = {a[26:0], a[31:27]} + f + e + w + k;
  assign digest = h[word_sel];

  always_ff @(posedge clk) begin
    if (ctl.init_work) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (ctl.do_round) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reinit_chain) begin
      h[0] <= H0_INIT;
      h[1] <= H1_INIT;
      h[2] <= H2_INIT;
      h[3] <= H3_INIT;
      h[4] <= H4_INIT;
    end else if (ctl.add_chain) begin
      h[0] <= h[0] + a;
      h[1] <= h[1] + b;
      h[2] <= h[2] + c;
      h[3] <= h[3] + d;
      h[4] <= h[4] + e;
    end
  end

endmodule

// File: rtl/core/sha1s_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1s_ctrl
// Sequencer: byte intake, padding, round count and digest beats.
// ---------------------------------------------------------------------------
module sha1s_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            byte_valid,
  input  logic            end_of_message,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_last,
  output logic [2:0]      word_sel,
  output sha1s_pkg::ctl_t ctl
);
  import sha1s_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [6:0]  rnd;
  logic        ending;
  logic        sent80;
  logic        len_phase;

  logic       in_acc;
  logic       out_acc;
  logic       len_sel;
  logic [7:0] pad_val;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign len_sel = sent80 && (len_phase || fill == LEN_POS);

  always_comb begin
    if (!sent80) begin
      pad_val = PAD_BYTE;
    end else if (len_sel) begin
      // length bytes go out most significant first
      pad_val = bit_count[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_val = 8'h00;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (byte_valid && fill == LAST_POS) begin
            state_next = ST_ROUND;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd == LAST_RND) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!ending) begin
          state_next = ST_IDLE;
        end else if (len_phase) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fill == LAST_POS) begin
          state_next = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (out_acc && out_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    out_valid        = 1'b0;
    ctl.push_byte    = 1'b0;
    ctl.push_val     = data_byte;
    ctl.do_round     = 1'b0;
    ctl.add_chain    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.push_byte = in_valid && byte_valid;
      end
      ST_ROUND: ctl.do_round = 1'b1;
      ST_FINAL: ctl.add_chain = 1'b1;
      ST_PAD: begin
        ctl.push_byte = 1'b1;
        ctl.push_val  = pad_val;
      end
      ST_EMIT: out_valid = 1'b1;
      default: ;
    endcase
    ctl.rnd          = rnd;
    ctl.init_work    = ctl.push_byte && fill == LAST_POS;
    out_last         = word_sel == LAST_WORD;
    ctl.reinit_chain = out_valid && out_ready && out_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      bit_count <= '0;
      rnd       <= '0;
      ending    <= 1'b0;
      sent80    <= 1'b0;
      len_phase <= 1'b0;
      word_sel  <= '0;
    end else begin
      state <= state_next;
      rnd   <= (state == ST_ROUND) ? rnd + 7'd1 : 7'd0;
      if (ctl.push_byte) begin
        fill <= fill + 6'd1;
      end
      if (in_acc) begin
        ending <= end_of_message;
        if (byte_valid) begin
          bit_count <= bit_count + 64'd8;
        end
      end
      if (state == ST_PAD) begin
        sent80 <= 1'b1;
        if (len_sel) begin
          len_phase <= 1'b1;
        end
      end
      if (out_acc) begin
        word_sel <= out_last ? 3'd0 : word_sel + 3'd1;
      end
      if (ctl.reinit_chain) begin
        fill      <= '0;
        bit_count <= '0;
        sent80    <= 1'b0;
        len_phase <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/sha1_stream_hasher.sv
`timescale 1ns / 1ps
// intake: input beats are taken while idle; the 64th byte of a block stops intake and
// starts 80 rounds through the one shared round unit, then the chaining add
// message end: 9 to 72 pad bytes, one per cycle, each full block compressed as above,
// then five digest beats, one per cycle while the output side is ready
// reset: synchronous, loads the initial chaining value and clears counts; no clearing pass
// ---------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 digest of a byte stream, one compression round per cycle.
// ---------------------------------------------------------------------------
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_number, rest zero
  output logic        m_axis_tlast    // last_word
);
  import sha1s_pkg::*;

  ctl_t       ctl;
  word_t      w;
  word_t      digest;
  logic [2:0] word_sel;

  sha1s_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .data_byte      (s_axis_tdata),
    .byte_valid     (s_axis_tuser),
    .end_of_message (s_axis_tlast),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_last       (m_axis_tlast),
    .word_sel       (word_sel),
    .ctl            (ctl)
  );

  sha1s_msg_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w   (w)
  );

  sha1s_round_unit u_round (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .w        (w),
    .word_sel (word_sel),
    .digest   (digest)
  );

  assign m_axis_tdata = {5'b0, word_sel, digest};

endmodule

// File: rtl/core/sha1s_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1s_checker
// Port-level checks on the hasher: digest beats and intake never overlap,
// and the five digest beats come out numbered in order.
// ---------------------------------------------------------------------------
module sha1s_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // no intake while a digest is pending
  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while digest beats pending");

  // tlast marks word number four
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd4)))
    else $error("tlast does not match word number");

  // words advance by one per beat
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("digest word sequence broken");

  // after the final digest beat the block takes input again
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after final digest beat");

  // a beat that does not end the message gives no digest next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> !m_axis_tvalid)
    else $error("digest without end of message");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
